>>> rtl/mse_pkg.sv
// shared types and constants for the moment snr level estimator
// no dependencies; imported by mse_mul and moment_snr_level_estimator
package mse_pkg;

  // defaults for the top level parameters
  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int ALPHA_FRAC_BITS_DEF = 16;

  // configuration register indexes and reset values
  localparam logic [0:0]  REG_ALPHA     = 1'b0;
  localparam logic [0:0]  REG_BLOCK_LEN = 1'b1;
  localparam logic [16:0] ALPHA_RESET   = 17'd1311;
  localparam logic [15:0] BLOCK_LEN_RESET = 16'd1024;

  // 10*log10(2) in q16
  localparam logic [31:0] DB_PER_OCTAVE_Q16 = 32'd197283;

  // multiplier operand width
  localparam int MUL_W = 32;

  // level status codes
  localparam logic LEVEL_OK        = 1'b0;
  localparam logic LEVEL_UNDEFINED = 1'b1;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQI,
    ST_SQQ,
    ST_PSUM,
    ST_YA,
    ST_YB,
    ST_YC,
    ST_YD,
    ST_WA,
    ST_WB,
    ST_WC,
    ST_WD,
    ST_WE,
    ST_UPD,
    ST_CHK,
    ST_CHK2,
    ST_SCALE,
    ST_SQRT,
    ST_LNORM,
    ST_LSQ,
    ST_LSQR,
    ST_LACC,
    ST_MUL,
    ST_RND,
    ST_OUT
  } state_t;

endpackage

>>> rtl/mse_mul.sv
// registered 32x32 unsigned multiplier shared by the sequencer steps that multiply
// depends on mse_pkg
module mse_mul (
  input  logic                        clk,
  input  logic [mse_pkg::MUL_W-1:0]   a,
  input  logic [mse_pkg::MUL_W-1:0]   b,
  output logic [2*mse_pkg::MUL_W-1:0] prod
);
  import mse_pkg::*;

  // product register
  always_ff @(posedge clk) begin
    prod <= {{MUL_W{1'b0}}, a} * {{MUL_W{1'b0}}, b};
  end

endmodule

>>> rtl/moment_snr_level_estimator.sv
// moment based snr level estimator, top level with sequencer and datapath
// depends on mse_pkg and mse_mul
//
// Each complex sample is taken on a valid/ready handshake and then worked on
// by a small sequencer around one shared registered 32x32 multiplier: the
// power, the two 64-bit wrapping moment products and the two exponential
// average updates are worked out in turn, while in_ready stays low.
// On the last sample of a block the level is formed with the same multiplier
// plus an iterative square root (32 steps per root, two roots), a one-bit
// per cycle normaliser for each of three base-2 logarithms (each followed by
// 16 squarings), a scale search and a final multiply and round; a block end
// with an undefined level skips all of these. The result sits in an output
// register, so the next sample is accepted while an estimate still waits to
// be taken. level_status high marks an undefined level, reported as zero.
module moment_snr_level_estimator #(
  parameter int SAMPLE_BITS     = mse_pkg::SAMPLE_BITS_DEF,
  parameter int ALPHA_FRAC_BITS = mse_pkg::ALPHA_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // sample channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_q,
  // estimate channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            level_db,
  output logic                          level_status,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_addr,
  input  logic [16:0]                   cfg_wdata
);
  import mse_pkg::*;

  localparam int PW = 2 * SAMPLE_BITS;
  localparam int F  = ALPHA_FRAC_BITS;
  localparam logic [MUL_W-1:0] ONE = MUL_W'(1) << F;

  state_t state, state_next;

  // configuration
  logic [16:0] alpha;
  logic [15:0] block_len;

  // per sample registers
  logic [SAMPLE_BITS-1:0] mag_i, mag_q;
  logic [PW-1:0]          p, prev_power;
  logic [63:0]            y, acc, avg_cross, avg_fourth;
  logic                   second;
  logic [15:0]            sample_count;

  // level registers
  logic [63:0]        d, n, z, nz;
  logic [4:0]         t;
  logic [63:0]        sx, sres, sbit;
  logic               ssel;
  logic [31:0]        sum;
  logic [63:0]        lx;
  logic [5:0]         le;
  logic [15:0]        lfrac;
  logic [3:0]         lk;
  logic [1:0]         lsel;
  logic [31:0]        m;
  logic signed [26:0] l;
  logic signed [15:0] res_db;
  logic               res_st;

  // shared multiplier
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] prod;

  mse_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // derived values
  logic [MUL_W-1:0] a_eff, a_comp;
  logic [63:0]      p64, b64, avg_sel;
  logic [15:0]      len, cnt_next;
  logic             blk_end, scale_go;
  logic [63:0]      trial, res_new;
  logic             sq_ge;
  logic [32:0]      mm;
  logic [21:0]      lv;
  logic [26:0]      l_mag;
  logic signed [63:0] v;
  logic signed [39:0] q;

  always_comb begin
    a_eff    = (MUL_W'(alpha) > ONE) ? ONE : MUL_W'(alpha);
    a_comp   = ONE - a_eff;
    p64      = 64'(p);
    b64      = second ? 64'(p) : 64'(prev_power);
    avg_sel  = second ? avg_fourth : avg_cross;
    len      = (block_len == 16'd0) ? 16'd1 : block_len;
    cnt_next = sample_count + 16'd1;
    blk_end  = !((cnt_next < len) && (cnt_next != 16'd0));
    scale_go = (t < 5'd31) && (z[63:60] == 4'd0);
    trial    = sres + sbit;
    sq_ge    = sx >= trial;
    res_new  = sq_ge ? ((sres >> 1) + sbit) : (sres >> 1);
    mm       = prod[63:31];
    lv       = {le, lfrac};
    l_mag    = l[26] ? 27'(-l) : 27'(l);
    v        = (l[26] ? -$signed(prod) : $signed(prod)) + 64'sd8388608;
    q        = 40'(v >>> 24);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_SQI;
      ST_SQI:   state_next = ST_SQQ;
      ST_SQQ:   state_next = ST_PSUM;
      ST_PSUM:  state_next = ST_YA;
      ST_YA:    state_next = ST_YB;
      ST_YB:    state_next = ST_YC;
      ST_YC:    state_next = ST_YD;
      ST_YD:    state_next = ST_WA;
      ST_WA:    state_next = ST_WB;
      ST_WB:    state_next = ST_WC;
      ST_WC:    state_next = ST_WD;
      ST_WD:    state_next = ST_WE;
      ST_WE:    state_next = second ? ST_UPD : ST_YA;
      ST_UPD:   state_next = blk_end ? ST_CHK : ST_IDLE;
      ST_CHK:   state_next = (avg_fourth <= avg_cross) ? ST_OUT : ST_CHK2;
      ST_CHK2:  state_next = (avg_cross <= d) ? ST_OUT : ST_SCALE;
      ST_SCALE: state_next = scale_go ? ST_SCALE : ST_SQRT;
      ST_SQRT:  state_next = (sbit == 64'd1 && ssel) ? ST_LNORM : ST_SQRT;
      ST_LNORM: state_next = lx[63] ? ST_LSQ : ST_LNORM;
      ST_LSQ:   state_next = ST_LSQR;
      ST_LSQR:  state_next = (lk == 4'd15) ? ST_LACC : ST_LSQ;
      ST_LACC:  state_next = (lsel == 2'd2) ? ST_MUL : ST_LNORM;
      ST_MUL:   state_next = ST_RND;
      ST_RND:   state_next = ST_OUT;
      ST_OUT:   state_next = (!out_valid || out_ready) ? ST_IDLE : ST_OUT;
      default:  state_next = ST_IDLE;
    endcase
  end

  // multiplier operands and handshake
  always_comb begin
    in_ready = (state == ST_IDLE) && !rst;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state)
      ST_SQI:  begin mul_a = MUL_W'(mag_i); mul_b = MUL_W'(mag_i); end
      ST_SQQ:  begin mul_a = MUL_W'(mag_q); mul_b = MUL_W'(mag_q); end
      ST_YA:   begin mul_a = p64[31:0];  mul_b = b64[31:0];  end
      ST_YB:   begin mul_a = p64[31:0];  mul_b = b64[63:32]; end
      ST_YC:   begin mul_a = p64[63:32]; mul_b = b64[31:0];  end
      ST_WA:   begin mul_a = a_eff;  mul_b = y[63:32]; end
      ST_WB:   begin mul_a = a_eff;  mul_b = y[31:0];  end
      ST_WC:   begin mul_a = a_comp; mul_b = avg_sel[63:32]; end
      ST_WD:   begin mul_a = a_comp; mul_b = avg_sel[31:0];  end
      ST_LSQ:  begin mul_a = m; mul_b = m; end
      ST_MUL:  begin mul_a = MUL_W'(l_mag); mul_b = DB_PER_OCTAVE_Q16; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      alpha        <= ALPHA_RESET;
      block_len    <= BLOCK_LEN_RESET;
      prev_power   <= '0;
      avg_cross    <= '0;
      avg_fourth   <= '0;
      sample_count <= '0;
      second       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;

      // configuration writes
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_ALPHA:     alpha     <= cfg_wdata;
          REG_BLOCK_LEN: block_len <= cfg_wdata[15:0];
          default:       alpha     <= alpha;
        endcase
      end

      // estimate register fill and drain
      if (state == ST_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready)                  out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          mag_i <= sample_i[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample_i) : sample_i;
          mag_q <= sample_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample_q) : sample_q;
        end
        ST_SQQ:  p <= PW'(prod);
        ST_PSUM: p <= p + PW'(prod);
        ST_YB:   y <= prod;
        ST_YC:   y <= y + (prod << 32);
        ST_YD:   y <= y + (prod << 32);
        ST_WB:   acc <= prod << (32 - F);
        ST_WC:   acc <= acc + (prod >> F);
        ST_WD:   acc <= acc + (prod << (32 - F));
        ST_WE: begin
          if (second) avg_fourth <= acc + (prod >> F);
          else        avg_cross  <= acc + (prod >> F);
          second <= 1'b1;
        end
        ST_UPD: begin
          prev_power   <= p;
          second       <= 1'b0;
          sample_count <= blk_end ? 16'd0 : cnt_next;
        end
        ST_CHK: begin
          d      <= avg_fourth - avg_cross;
          res_db <= '0;
          res_st <= LEVEL_UNDEFINED;
          if (avg_fourth <= avg_cross) begin
            avg_cross  <= '0;
            avg_fourth <= '0;
          end
        end
        ST_CHK2: begin
          n          <= avg_cross - d;
          nz         <= avg_cross - d;
          z          <= avg_cross;
          t          <= '0;
          avg_cross  <= '0;
          avg_fourth <= '0;
        end
        // scale search, then first root on the shifted n
        ST_SCALE: begin
          if (scale_go) begin
            z  <= z << 2;
            nz <= nz << 2;
            t  <= t + 5'd1;
          end else begin
            sx   <= nz;
            sres <= '0;
            sbit <= 64'd1 << 62;
            ssel <= 1'b0;
            l    <= -$signed({6'd0, t, 16'd0});
          end
        end
        // one root step a cycle
        ST_SQRT: begin
          if (sbit == 64'd1) begin
            if (!ssel) begin
              sum  <= res_new[31:0];
              sx   <= z;
              sres <= '0;
              sbit <= 64'd1 << 62;
              ssel <= 1'b1;
            end else begin
              sum   <= sum + res_new[31:0];
              lx    <= n;
              le    <= 6'd63;
              lfrac <= '0;
              lk    <= '0;
              lsel  <= 2'd0;
            end
          end else begin
            if (sq_ge) sx <= sx - trial;
            sres <= res_new;
            sbit <= sbit >> 2;
          end
        end
        // normalise one bit a cycle
        ST_LNORM: begin
          if (!lx[63]) begin
            lx <= lx << 1;
            le <= le - 6'd1;
          end else begin
            m <= lx[63:32];
          end
        end
        ST_LSQR: begin
          lfrac <= {lfrac[14:0], mm[32]};
          m     <= mm[32] ? mm[32:1] : mm[31:0];
          lk    <= lk + 4'd1;
        end
        ST_LACC: begin
          case (lsel)
            2'd0:    l <= l + $signed({6'd0, lv[21:1]});
            2'd1:    l <= l + $signed({5'd0, lv});
            default: l <= l - $signed({5'd0, lv});
          endcase
          lx    <= (lsel == 2'd0) ? 64'(sum) : d;
          le    <= 6'd63;
          lfrac <= '0;
          lk    <= '0;
          lsel  <= lsel + 2'd1;
        end
        // round half up and saturate
        ST_RND: begin
          res_st <= LEVEL_OK;
          if (q > 40'sd32767)       res_db <= 16'sd32767;
          else if (q < -40'sd32768) res_db <= -16'sd32768;
          else                      res_db <= q[15:0];
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            level_db     <= res_db;
            level_status <= res_st;
          end
        end
        default: ;
      endcase
    end
  end

  // a sample is worked on before the next one is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sample accepted back to back");

  // an undefined level is always reported as zero
  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && level_status == LEVEL_UNDEFINED) |-> (level_db == 16'sd0))
    else $error("undefined level not zero");

  // the root step bit stays a single bit
  a_sqrt_bit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQRT) |-> $onehot(sbit))
    else $error("root step bit corrupt");

  // an empty output register is filled when the estimate is ready
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !out_valid) |=> out_valid)
    else $error("estimate not loaded");

endmodule

>>> tb/moment_snr_level_estimator_tb.sv
// self-checking testbench for the moment snr level estimator
// depends on mse_pkg and moment_snr_level_estimator; directed table, then random phases
module moment_snr_level_estimator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mse_pkg::*;

  localparam int FB = ALPHA_FRAC_BITS_DEF;
  localparam longint LIMIT = 3000000;
  localparam int SETTLE = 600;

  typedef enum logic {RK_SAMPLE, RK_CFG} row_kind_t;
  typedef struct {
    row_kind_t         kind;
    logic signed [15:0] si;
    logic signed [15:0] sq;
    logic [0:0]        addr;
    logic [16:0]       data;
    bit                typed;
    logic signed [15:0] db;
    logic              st;
  } row_t;
  typedef struct {
    logic signed [15:0] db;
    logic              st;
  } level_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] sample_i = '0;
  logic signed [15:0] sample_q = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] level_db;
  logic level_status;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_addr = '0;
  logic [16:0] cfg_wdata = '0;

  // predictor state and its copy of the registers
  longint unsigned prev_pw, avg_x, avg_sq;
  bit [15:0] blk_cnt;
  bit [16:0] alpha_r;
  bit [15:0] blen_r;

  level_t levels_due[$];
  int n_fail = 0;
  int n_items = 0;
  int n_levels = 0;
  int n_defined = 0;
  longint cycles = 0;
  int send_idle = 0;
  int recv_stall = 0;

  moment_snr_level_estimator u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .sample_i(sample_i), .sample_q(sample_q),
    .out_valid(out_valid), .out_ready(out_ready), .level_db(level_db),
    .level_status(level_status),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // floor(y*w / 2^FB), wrapping at 64 bits
  function automatic longint unsigned wscale(longint unsigned y, longint unsigned w);
    return ((w * (y >> 32)) << (32 - FB)) + ((w * (y & 64'hFFFF_FFFF)) >> FB);
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // log2 in q16, fraction by repeated squaring of a q1.31 mantissa
  function automatic longint log2_q16(longint unsigned x);
    int e;
    longint unsigned m;
    longint frac;
    e = 63;
    frac = 0;
    if (x == 0) return 0;
    while (x[e] == 1'b0) e--;
    if (e >= 31) m = x >> (e - 31);
    else m = x << (31 - e);
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        frac = frac | 1;
        m >>= 1;
      end
    end
    return (longint'(e) <<< 16) + frac;
  endfunction

  function automatic level_t level_from(longint unsigned a1, longint unsigned a2);
    level_t r;
    longint unsigned d, n, s;
    longint l, v, qq;
    int t;
    r.db = '0;
    r.st = LEVEL_UNDEFINED;
    if (a2 <= a1) return r;
    d = a2 - a1;
    if (a1 <= d) return r;
    n = a1 - d;
    t = 0;
    while (t < 31 && (a1 >> (60 - 2 * t)) == 0) t++;
    s = root64(n << (2 * t)) + root64(a1 << (2 * t));
    l = (log2_q16(n) / 2) + log2_q16(s) - (longint'(t) <<< 16) - log2_q16(d);
    v = l * longint'(DB_PER_OCTAVE_Q16) + (longint'(1) <<< 23);
    if (v >= 0) qq = v / (longint'(1) <<< 24);
    else qq = -((-v + (longint'(1) <<< 24) - 1) / (longint'(1) <<< 24));
    if (qq > 32767) qq = 32767;
    if (qq < -32768) qq = -32768;
    r.db = qq[15:0];
    r.st = LEVEL_OK;
    return r;
  endfunction

  // advance the predictor by one sample; returns 1 when a block closes
  function automatic bit predict_level(logic signed [15:0] si, logic signed [15:0] sq,
                                       output level_t lv);
    longint sx, sy;
    longint unsigned p, one, a;
    bit [15:0] len;
    sx = si;
    sy = sq;
    p = longint'(sx * sx) + longint'(sy * sy);
    one = 64'd1 << FB;
    a = (alpha_r > one) ? one : alpha_r;
    len = (blen_r == 0) ? 16'd1 : blen_r;
    avg_x = wscale(p * prev_pw, a) + wscale(avg_x, one - a);
    avg_sq = wscale(p * p, a) + wscale(avg_sq, one - a);
    prev_pw = p;
    blk_cnt = blk_cnt + 16'd1;
    if (blk_cnt < len && blk_cnt != 0) return 0;
    lv = level_from(avg_x, avg_sq);
    avg_x = 0;
    avg_sq = 0;
    blk_cnt = 0;
    return 1;
  endfunction

  // drain outstanding levels, then let any block-end work finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] addr, logic [16:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == REG_ALPHA) alpha_r = data;
    else blen_r = data[15:0];
    @(posedge clk);
  endtask

  // one sample item; a typed level replaces the predicted one
  task automatic send_sample(logic signed [15:0] si, logic signed [15:0] sq,
                             bit typed, level_t typed_lv);
    level_t lv;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_i <= si;
    sample_q <= sq;
    do @(posedge clk); while (!in_ready);
    n_items++;
    if (predict_level(si, sq, lv)) levels_due.push_back(typed ? typed_lv : lv);
  endtask

  task automatic pick_sample(output logic signed [15:0] si, output logic signed [15:0] sq);
    int amp, nz;
    if ($urandom_range(99) < 20) begin
      si = 16'($urandom);
      sq = 16'($urandom);
    end else begin
      // constant-envelope tone with some noise, the case that gives defined levels
      amp = $urandom_range(20000, 50);
      nz = amp >> $urandom_range(6, 1);
      si = 16'(($urandom_range(1) ? amp : -amp) + int'($urandom_range(2 * nz)) - nz);
      sq = 16'(($urandom_range(1) ? amp : -amp) + int'($urandom_range(2 * nz)) - nz);
    end
  endtask

  // estimate checker and receiver stalls
  always @(posedge clk) begin
    level_t e;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      if (levels_due.size() == 0) begin
        $error("estimate with none expected: level_db %0d level_status %0b",
               level_db, level_status);
        n_fail++;
      end else begin
        e = levels_due.pop_front();
        n_levels++;
        if (e.st == LEVEL_OK) n_defined++;
        if (level_db !== e.db) begin
          $error("level_db expected %0d actual %0d", e.db, level_db);
          n_fail++;
        end
        if (level_status !== e.st) begin
          $error("level_status expected %0b actual %0b", e.st, level_status);
          n_fail++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  initial begin
    row_t rows[$];
    row_t r;
    level_t tl;
    level_t undef;
    logic signed [15:0] si, sq;
    int a_sel;

    undef.db = '0;
    undef.st = LEVEL_UNDEFINED;
    alpha_r = ALPHA_RESET;
    blen_r = BLOCK_LEN_RESET;
    prev_pw = 0;
    avg_x = 0;
    avg_sq = 0;
    blk_cnt = 0;

    // directed rows: kind, i, q, reg index, reg data, typed, level, status
    rows.push_back('{RK_CFG, 0, 0, REG_ALPHA, 17'd65536, 0, 0, 0});
    rows.push_back('{RK_CFG, 0, 0, REG_BLOCK_LEN, 17'd1, 0, 0, 0});
    rows.push_back('{RK_SAMPLE, 0, 0, 0, 0, 1, 0, LEVEL_UNDEFINED});            // zero input
    rows.push_back('{RK_SAMPLE, -32768, -32768, 0, 0, 1, 0, LEVEL_UNDEFINED});  // prev power zero
    rows.push_back('{RK_SAMPLE, -32768, -32768, 0, 0, 1, 0, LEVEL_UNDEFINED});  // equal moments
    rows.push_back('{RK_SAMPLE, 32767, 32767, 0, 0, 1, 0, LEVEL_UNDEFINED});    // falling power
    rows.push_back('{RK_SAMPLE, 32767, -32768, 0, 0, 0, 0, 0});
    rows.push_back('{RK_SAMPLE, 100, 0, 0, 0, 0, 0, 0});
    rows.push_back('{RK_SAMPLE, 101, 0, 0, 0, 0, 0, 0});
    rows.push_back('{RK_SAMPLE, -1, 1, 0, 0, 0, 0, 0});
    rows.push_back('{RK_CFG, 0, 0, REG_BLOCK_LEN, 17'd0, 0, 0, 0});             // length zero acts as one
    rows.push_back('{RK_SAMPLE, 7, -7, 0, 0, 0, 0, 0});
    rows.push_back('{RK_SAMPLE, 8, -7, 0, 0, 0, 0, 0});
    rows.push_back('{RK_CFG, 0, 0, REG_ALPHA, 17'd131071, 0, 0, 0});            // alpha above one
    rows.push_back('{RK_SAMPLE, 0, -32768, 0, 0, 0, 0, 0});
    rows.push_back('{RK_SAMPLE, 1, -32768, 0, 0, 0, 0, 0});
    rows.push_back('{RK_CFG, 0, 0, REG_ALPHA, 17'd0, 0, 0, 0});                 // averages stay zero
    rows.push_back('{RK_SAMPLE, 12345, -2222, 0, 0, 1, 0, LEVEL_UNDEFINED});
    rows.push_back('{RK_CFG, 0, 0, REG_ALPHA, 17'd1311, 0, 0, 0});
    rows.push_back('{RK_CFG, 0, 0, REG_BLOCK_LEN, 17'd65535, 0, 0, 0});
    for (int k = 0; k < 5; k++)
      rows.push_back('{RK_SAMPLE, 3000 + k, -3000, 0, 0, 0, 0, 0});
    rows.push_back('{RK_CFG, 0, 0, REG_BLOCK_LEN, 17'd3, 0, 0, 0});             // lowered mid-block
    rows.push_back('{RK_SAMPLE, 3001, -2999, 0, 0, 0, 0, 0});

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    foreach (rows[k]) begin
      r = rows[k];
      tl.db = r.db;
      tl.st = r.st;
      if (r.kind == RK_CFG) begin
        wait_idle();
        write_reg(r.addr, r.data);
      end else begin
        send_sample(r.si, r.sq, r.typed, tl);
      end
    end

    // random phases, each with its own settings and idling pattern
    for (int ph = 0; ph < 12; ph++) begin
      wait_idle();
      a_sel = ph % 6;
      case (a_sel)
        0: write_reg(REG_ALPHA, 17'd1311);
        1: write_reg(REG_ALPHA, 17'd65536);
        2: write_reg(REG_ALPHA, 17'd131071);
        3: write_reg(REG_ALPHA, 17'($urandom_range(65535, 30000)));
        4: write_reg(REG_ALPHA, 17'd0);
        default: write_reg(REG_ALPHA, 17'($urandom_range(65535, 1)));
      endcase
      if (ph == 7) write_reg(REG_BLOCK_LEN, 17'd0);
      else if (ph == 9) write_reg(REG_BLOCK_LEN, 17'd16);
      else write_reg(REG_BLOCK_LEN, 17'($urandom_range(6, 1)));
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 61; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 61; end
        default: begin send_idle = 24; recv_stall = 24; end
      endcase
      for (int k = 0; k < 71; k++) begin
        // hold the sender back until every pending level is out
        if (ph == 5 && k == 35) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (levels_due.size() != 0) @(posedge clk);
        end
        pick_sample(si, sq);
        send_sample(si, sq, 0, undef);
      end
    end

    send_idle = 0;
    recv_stall = 0;
    wait_idle();
    if (levels_due.size() != 0) n_fail++;
    $display("covered %0d samples and %0d levels (%0d defined) over 12 random phases",
             n_items, n_levels, n_defined);
    $display("settings swept alpha 0 to above one and block length 0 to 65535");
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
